>>> rtl/tcpfsm_pkg.sv
// ----------------------------------------------------------------------------
// tcpfsm_pkg
// Types and codes shared by the TCP connection state machine block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpfsm_pkg;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned LenW  = 16;
  localparam int unsigned FlagW = 3;
  localparam int unsigned FuncW = 3;
  localparam int unsigned StW   = 4;

  localparam logic [FlagW-1:0] FlagSyn = 3'd1;
  localparam logic [FlagW-1:0] FlagAck = 3'd2;
  localparam logic [FlagW-1:0] FlagFin = 3'd4;

  typedef enum logic [StW-1:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RCVD    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_FIN_WAIT_1  = 4'd5,
    ST_FIN_WAIT_2  = 4'd6,
    ST_WAIT_2MSL   = 4'd7,
    ST_CLOSE_WAIT  = 4'd8,
    ST_LAST_ACK    = 4'd9
  } conn_state_e;

  typedef enum logic [FuncW-1:0] {
    FN_LISTEN  = 3'd0,
    FN_OPEN    = 3'd1,
    FN_SEND    = 3'd2,
    FN_CLOSE   = 3'd3,
    FN_TICK    = 3'd4,
    FN_SEGMENT = 3'd5
  } func_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [FlagW-1:0] seg_flags;
    logic [SeqW-1:0]  seg_seq;
    logic [LenW-1:0]  seg_len;
    logic [LenW-1:0]  send_len;
  } evt_t;

  typedef struct packed {
    logic             reply_present;
    logic [FlagW-1:0] reply_flags;
    logic [SeqW-1:0]  reply_seq;
    logic [SeqW-1:0]  reply_ack;
    logic [LenW-1:0]  reply_len;
    logic [StW-1:0]   conn_state;
    logic             seg_accepted;
    logic [SeqW-1:0]  reject_total;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/tcpfsm_evt_if.sv
// ----------------------------------------------------------------------------
// tcpfsm_evt_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpfsm_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [2:0]  seg_flags;
  logic [31:0] seg_seq;
  logic [15:0] seg_len;
  logic [15:0] send_len;

  modport source (output valid, func, seg_flags, seg_seq, seg_len, send_len,
                  input ready);
  modport sink   (input valid, func, seg_flags, seg_seq, seg_len, send_len,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/tcpfsm_res_if.sv
// ----------------------------------------------------------------------------
// tcpfsm_res_if
// Result channel: valid/ready handshake with reply segment and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpfsm_res_if;
  logic        valid;
  logic        ready;
  logic        reply_present;
  logic [2:0]  reply_flags;
  logic [31:0] reply_seq;
  logic [31:0] reply_ack;
  logic [15:0] reply_len;
  logic [3:0]  conn_state;
  logic        seg_accepted;
  logic [31:0] reject_total;

  modport source (output valid, reply_present, reply_flags, reply_seq, reply_ack,
                  reply_len, conn_state, seg_accepted, reject_total,
                  input ready);
  modport sink   (input valid, reply_present, reply_flags, reply_seq, reply_ack,
                  reply_len, conn_state, seg_accepted, reject_total,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/tcpfsm_in_stage.sv
// ----------------------------------------------------------------------------
// tcpfsm_in_stage
// Input register stage for event transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpfsm_in_stage
  import tcpfsm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic up_valid_i,
  output logic      up_ready_o,
  input  wire evt_t up_data_i,
  output logic      dn_valid_o,
  input  wire logic dn_ready_i,
  output evt_t      dn_data_o
);

  logic valid_q;
  evt_t data_q;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= up_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcpfsm_engine.sv
// ----------------------------------------------------------------------------
// tcpfsm_engine
// Connection state, sequence tracking and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpfsm_engine
  import tcpfsm_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [SeqW-1:0] iss_i,
  input  wire logic            evt_valid_i,
  output logic                 evt_ready_o,
  input  wire evt_t            evt_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output res_t                 res_o
);

  conn_state_e     st_q, st_d;
  logic [SeqW-1:0] snd_nxt_q, snd_nxt_d;
  logic [SeqW-1:0] rcv_nxt_q, rcv_nxt_d;
  logic            acc_q, acc_d;
  logic [SeqW-1:0] rej_q, rej_d;
  logic            res_valid_q;
  res_t            res_q, res_d;
  logic            fire;
  logic            syn, ack, fin;

  assign evt_ready_o = !res_valid_q || res_ready_i;
  assign fire        = evt_valid_i && evt_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign syn = |(evt_i.seg_flags & FlagSyn);
  assign ack = |(evt_i.seg_flags & FlagAck);
  assign fin = |(evt_i.seg_flags & FlagFin);

  always_comb begin
    st_d      = st_q;
    snd_nxt_d = snd_nxt_q;
    rcv_nxt_d = rcv_nxt_q;
    acc_d     = acc_q;
    rej_d     = rej_q;
    res_d     = '0;
    case (evt_i.func)
      FN_LISTEN: begin
        st_d = ST_LISTEN;
      end
      FN_OPEN: begin
        res_d.reply_present = 1'b1;
        res_d.reply_flags   = FlagSyn;
        res_d.reply_seq     = iss_i;
        snd_nxt_d           = iss_i + 32'd1;
        st_d                = ST_SYN_SENT;
      end
      FN_SEND: begin
        if (st_q == ST_ESTABLISHED) begin
          res_d.reply_present = 1'b1;
          res_d.reply_flags   = FlagAck;
          res_d.reply_seq     = snd_nxt_q;
          res_d.reply_ack     = rcv_nxt_q;
          res_d.reply_len     = evt_i.send_len;
          snd_nxt_d           = snd_nxt_q + {16'd0, evt_i.send_len};
        end
      end
      FN_CLOSE: begin
        if (st_q == ST_ESTABLISHED || st_q == ST_CLOSE_WAIT) begin
          res_d.reply_present = 1'b1;
          res_d.reply_flags   = FlagFin;
          res_d.reply_seq     = snd_nxt_q;
          res_d.reply_ack     = rcv_nxt_q;
          snd_nxt_d           = snd_nxt_q + 32'd1;
          st_d = (st_q == ST_ESTABLISHED) ? ST_FIN_WAIT_1 : ST_LAST_ACK;
        end
      end
      FN_TICK: begin
        if (st_q == ST_WAIT_2MSL) begin
          st_d = ST_CLOSED;
        end
      end
      FN_SEGMENT: begin
        acc_d = 1'b1;
        if (st_q == ST_LISTEN && syn && !ack) begin
          rcv_nxt_d           = evt_i.seg_seq + 32'd1;
          res_d.reply_present = 1'b1;
          res_d.reply_flags   = FlagSyn | FlagAck;
          res_d.reply_seq     = iss_i;
          res_d.reply_ack     = rcv_nxt_d;
          snd_nxt_d           = iss_i + 32'd1;
          st_d                = ST_SYN_RCVD;
        end else if (st_q == ST_SYN_SENT && syn && ack) begin
          rcv_nxt_d           = evt_i.seg_seq + 32'd1;
          res_d.reply_present = 1'b1;
          res_d.reply_flags   = FlagAck;
          res_d.reply_seq     = snd_nxt_q;
          res_d.reply_ack     = rcv_nxt_d;
          st_d                = ST_ESTABLISHED;
        end else if (st_q == ST_SYN_RCVD && ack && !syn) begin
          st_d = ST_ESTABLISHED;
        end else if (st_q == ST_ESTABLISHED && evt_i.seg_len != '0) begin
          rcv_nxt_d           = evt_i.seg_seq + {16'd0, evt_i.seg_len};
          res_d.reply_present = 1'b1;
          res_d.reply_flags   = FlagAck;
          res_d.reply_seq     = snd_nxt_q;
          res_d.reply_ack     = rcv_nxt_d;
        end else if (st_q == ST_ESTABLISHED && ack && !fin) begin
          st_d = ST_ESTABLISHED;
        end else if (st_q == ST_ESTABLISHED && fin) begin
          rcv_nxt_d           = evt_i.seg_seq + 32'd1;
          res_d.reply_present = 1'b1;
          res_d.reply_flags   = FlagAck;
          res_d.reply_seq     = snd_nxt_q;
          res_d.reply_ack     = rcv_nxt_d;
          st_d                = ST_CLOSE_WAIT;
        end else if (st_q == ST_FIN_WAIT_1 && ack && !fin) begin
          st_d = ST_FIN_WAIT_2;
        end else if (st_q == ST_FIN_WAIT_2 && fin) begin
          rcv_nxt_d           = evt_i.seg_seq + 32'd1;
          res_d.reply_present = 1'b1;
          res_d.reply_flags   = FlagAck;
          res_d.reply_seq     = snd_nxt_q;
          res_d.reply_ack     = rcv_nxt_d;
          st_d                = ST_WAIT_2MSL;
        end else if (st_q == ST_LAST_ACK && ack) begin
          st_d = ST_CLOSED;
        end else begin
          acc_d = 1'b0;
          rej_d = rej_q + 32'd1;
        end
      end
      default: begin
      end
    endcase
    res_d.conn_state   = st_d;
    res_d.seg_accepted = acc_d;
    res_d.reject_total = rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLOSED;
      snd_nxt_q   <= '0;
      rcv_nxt_q   <= '0;
      acc_q       <= 1'b0;
      rej_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (evt_ready_o) begin
        res_valid_q <= evt_valid_i;
      end
      if (fire) begin
        st_q      <= st_d;
        snd_nxt_q <= snd_nxt_d;
        rcv_nxt_q <= rcv_nxt_d;
        acc_q     <= acc_d;
        rej_q     <= rej_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcp_connection_fsm_unit.sv
// ----------------------------------------------------------------------------
// tcp_connection_fsm_unit
// One TCP endpoint: connection state machine with reply segment generation.
// ----------------------------------------------------------------------------
// Takes one event transaction per clock and returns exactly one result
// transaction per event, in order. An event passes an input register and is
// then processed against the connection state combinationally, the result
// landing in an output register from which it is offered. Throughput is one
// event per cycle as long as the result side keeps taking transactions; a
// stalled result side holds off new events once both registers are full. The
// initial send sequence number is written through cfg_we_i/cfg_wdata_i while
// no event is in flight; it takes effect at the next open or passive SYN.
`default_nettype none

module tcp_connection_fsm_unit
  import tcpfsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  tcpfsm_evt_if.sink       evt_i,
  tcpfsm_res_if.source     res_o
);

  logic [SeqW-1:0] iss_q;
  evt_t            evt_in;
  evt_t            evt_reg;
  logic            evt_reg_valid;
  logic            evt_reg_ready;
  res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
    end else if (cfg_we_i) begin
      iss_q <= cfg_wdata_i;
    end
  end

  assign evt_in.func      = evt_i.func;
  assign evt_in.seg_flags = evt_i.seg_flags;
  assign evt_in.seg_seq   = evt_i.seg_seq;
  assign evt_in.seg_len   = evt_i.seg_len;
  assign evt_in.send_len  = evt_i.send_len;

  tcpfsm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (evt_i.valid),
    .up_ready_o (evt_i.ready),
    .up_data_i  (evt_in),
    .dn_valid_o (evt_reg_valid),
    .dn_ready_i (evt_reg_ready),
    .dn_data_o  (evt_reg)
  );

  tcpfsm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_i       (iss_q),
    .evt_valid_i (evt_reg_valid),
    .evt_ready_o (evt_reg_ready),
    .evt_i       (evt_reg),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.reply_present = res.reply_present;
  assign res_o.reply_flags   = res.reply_flags;
  assign res_o.reply_seq     = res.reply_seq;
  assign res_o.reply_ack     = res.reply_ack;
  assign res_o.reply_len     = res.reply_len;
  assign res_o.conn_state    = res.conn_state;
  assign res_o.seg_accepted  = res.seg_accepted;
  assign res_o.reject_total  = res.reject_total;

endmodule

`default_nettype wire
